FILE: sv/nfcs_pkg.sv
package nfcs_pkg;

    localparam int SECTOR_WORDS = 65536;
    localparam int ADDR_BITS    = 23;
    localparam int CNT_BITS     = (SECTOR_WORDS > 1) ? $clog2(SECTOR_WORDS) : 1;
    localparam logic [CNT_BITS-1:0] LAST_WORD = CNT_BITS'(SECTOR_WORDS - 1);

    localparam logic [7:0] CMD_STATUS     = 8'h01;
    localparam logic [7:0] CMD_PING_A     = 8'h02;
    localparam logic [7:0] CMD_PING_B     = 8'h03;
    localparam logic [7:0] CMD_DRIVE_OFF  = 8'h04;
    localparam logic [7:0] CMD_DRIVE_ON   = 8'h05;
    localparam logic [7:0] CMD_TRI_OFF    = 8'h06;
    localparam logic [7:0] CMD_TRI_ON     = 8'h07;
    localparam logic [7:0] CMD_RST_OFF    = 8'h08;
    localparam logic [7:0] CMD_RST_ON     = 8'h09;
    localparam logic [7:0] CMD_WAIT       = 8'h0E;
    localparam logic [7:0] CMD_WAIT_INC   = 8'h0F;
    localparam logic [7:0] CMD_READ_FIRST = 8'h10;
    localparam logic [7:0] CMD_READ_LAST  = 8'h13;
    localparam logic [7:0] CMD_WRITE      = 8'h18;
    localparam logic [7:0] CMD_WRITE_INC  = 8'h19;
    localparam logic [7:0] CMD_DELAY_LO   = 8'h40;
    localparam logic [7:0] CMD_DELAY_HI   = 8'h7F;
    localparam logic [7:0] CMD_ADDR_LO    = 8'h80;
    localparam logic [7:0] CMD_ADDR_HI    = 8'hFF;

    localparam logic [7:0] PING_A_REPLY   = 8'h42;
    localparam logic [7:0] PING_B_REPLY   = 8'hBD;

    localparam logic [1:0] TX_NONE = 2'd0;
    localparam logic [1:0] TX_ONE  = 2'd1;
    localparam logic [1:0] TX_TWO  = 2'd2;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  host_byte;
        logic        ready_busy;
        logic [15:0] flash_data;
    } item_t;

    typedef struct packed {
        logic                 byte_accepted;
        logic [1:0]           tx_count;
        logic [15:0]          tx_data;
        logic [ADDR_BITS-1:0] flash_address;
        logic [15:0]          write_data;
        logic                 data_drive;
        logic                 output_enable_n;
        logic                 write_enable_n;
        logic                 reset_n;
        logic                 tristate;
    } result_t;

endpackage

FILE: sv/nfcs_input_stage.sv
module nfcs_input_stage import nfcs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  item_t item_in,
    input  logic  advance,
    output logic  valid,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

FILE: sv/nfcs_core.sv
module nfcs_core import nfcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    output result_t result
);

    typedef enum logic [3:0] {
        M_IDLE,
        M_DELAY,
        M_ADDR_MID,
        M_ADDR_LOW,
        M_READ,
        M_DATA_HI,
        M_DATA_LO,
        M_WE_PULSE,
        M_WAIT
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic [5:0]           delay_reg, delay_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [15:0]          latch_reg, latch_next;
    logic                 inc_reg, inc_next;
    logic                 drive_reg, drive_next;
    logic                 tri_reg, tri_next;
    logic                 rstn_reg, rstn_next;
    logic                 oen_reg, oen_next;
    logic                 wen_reg, wen_next;
    logic                 bus_reg, bus_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;

    logic [31:0]          addr_wide;
    logic [ADDR_BITS-1:0] addr_plus;
    logic [7:0]           status;
    logic [7:0]           b;
    logic                 accepted;
    logic [1:0]           txc;
    logic [15:0]          txd;

    assign b         = item.host_byte;
    assign addr_wide = 32'(addr_reg);
    assign addr_plus = addr_reg + 1'b1;
    assign status    = {1'b0, drive_reg, tri_reg, rstn_reg, item.ready_busy,
                        1'b0, wen_reg, oen_reg};

    always_comb
    begin
        mode_next  = mode_reg;
        delay_next = delay_reg;
        addr_next  = addr_reg;
        latch_next = latch_reg;
        inc_next   = inc_reg;
        drive_next = drive_reg;
        tri_next   = tri_reg;
        rstn_next  = rstn_reg;
        oen_next   = oen_reg;
        wen_next   = wen_reg;
        bus_next   = bus_reg;
        count_next = count_reg;
        accepted   = 1'b0;
        txc        = TX_NONE;
        txd        = 16'h0000;
        case (mode_reg)
            M_IDLE:
            begin
                if (item.byte_valid)
                begin
                    accepted = 1'b1;
                    case (b) inside
                        CMD_STATUS:
                        begin
                            txd = {8'h00, status};
                            txc = TX_ONE;
                        end
                        CMD_PING_A:
                        begin
                            txd = {8'h00, PING_A_REPLY};
                            txc = TX_ONE;
                        end
                        CMD_PING_B:
                        begin
                            txd = {8'h00, PING_B_REPLY};
                            txc = TX_ONE;
                        end
                        CMD_DRIVE_OFF, CMD_DRIVE_ON:
                        begin
                            drive_next = b[0];
                        end
                        CMD_TRI_OFF, CMD_TRI_ON:
                        begin
                            tri_next = b[0];
                        end
                        CMD_RST_OFF, CMD_RST_ON:
                        begin
                            rstn_next = ~b[0];
                        end
                        CMD_WAIT, CMD_WAIT_INC:
                        begin
                            inc_next  = b[0];
                            mode_next = M_WAIT;
                        end
                        [CMD_READ_FIRST:CMD_READ_LAST]:
                        begin
                            inc_next   = b[0];
                            bus_next   = 1'b0;
                            oen_next   = 1'b0;
                            count_next = '0;
                            mode_next  = M_READ;
                        end
                        CMD_WRITE, CMD_WRITE_INC:
                        begin
                            inc_next  = b[0];
                            mode_next = M_DATA_HI;
                        end
                        [CMD_DELAY_LO:CMD_DELAY_HI]:
                        begin
                            delay_next = b[5:0];
                            mode_next  = M_DELAY;
                        end
                        [CMD_ADDR_LO:CMD_ADDR_HI]:
                        begin
                            addr_next = ADDR_BITS'({9'h000, b[6:0], addr_wide[15:0]});
                            mode_next = M_ADDR_MID;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            M_DELAY:
            begin
                if (delay_reg == 6'd0)
                begin
                    mode_next = M_IDLE;
                end
                else
                begin
                    delay_next = delay_reg - 6'd1;
                end
            end
            M_ADDR_MID:
            begin
                if (item.byte_valid)
                begin
                    accepted  = 1'b1;
                    addr_next = ADDR_BITS'({addr_wide[31:16], b, addr_wide[7:0]});
                    mode_next = M_ADDR_LOW;
                end
            end
            M_ADDR_LOW:
            begin
                if (item.byte_valid)
                begin
                    accepted  = 1'b1;
                    addr_next = ADDR_BITS'({addr_wide[31:8], b});
                    mode_next = M_IDLE;
                end
            end
            M_READ:
            begin
                txc       = TX_TWO;
                txd       = item.flash_data;
                addr_next = addr_plus;
                if (count_reg >= LAST_WORD)
                begin
                    count_next = '0;
                    oen_next   = 1'b1;
                    bus_next   = 1'b1;
                    mode_next  = M_IDLE;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            M_DATA_HI:
            begin
                if (item.byte_valid)
                begin
                    accepted   = 1'b1;
                    latch_next = {b, latch_reg[7:0]};
                    mode_next  = M_DATA_LO;
                end
            end
            M_DATA_LO:
            begin
                if (item.byte_valid)
                begin
                    accepted   = 1'b1;
                    latch_next = {latch_reg[15:8], b};
                    wen_next   = 1'b0;
                    mode_next  = M_WE_PULSE;
                end
            end
            M_WE_PULSE:
            begin
                wen_next = 1'b1;
                if (inc_reg)
                begin
                    addr_next = addr_plus;
                end
                mode_next = M_IDLE;
            end
            M_WAIT:
            begin
                if (item.ready_busy)
                begin
                    if (inc_reg)
                    begin
                        addr_next = addr_plus;
                    end
                    mode_next = M_IDLE;
                end
            end
            default:
            begin
                mode_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            delay_reg <= '0;
            addr_reg  <= '0;
            latch_reg <= '0;
            inc_reg   <= 1'b0;
            drive_reg <= 1'b0;
            tri_reg   <= 1'b0;
            rstn_reg  <= 1'b1;
            oen_reg   <= 1'b1;
            wen_reg   <= 1'b1;
            bus_reg   <= 1'b1;
            count_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            delay_reg <= delay_next;
            addr_reg  <= addr_next;
            latch_reg <= latch_next;
            inc_reg   <= inc_next;
            drive_reg <= drive_next;
            tri_reg   <= tri_next;
            rstn_reg  <= rstn_next;
            oen_reg   <= oen_next;
            wen_reg   <= wen_next;
            bus_reg   <= bus_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        result.byte_accepted   = accepted;
        result.tx_count        = txc;
        result.tx_data         = txd;
        result.flash_address   = addr_next;
        result.write_data      = latch_next;
        result.data_drive      = bus_next;
        result.output_enable_n = oen_next;
        result.write_enable_n  = wen_next;
        result.reset_n         = rstn_next;
        result.tristate        = tri_next;
    end

endmodule

FILE: sv/nfcs_output_stage.sv
module nfcs_output_stage import nfcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_in,
    input  logic    stall,
    output logic    valid,
    output result_t result
);

    logic    valid_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign valid  = valid_reg;
    assign result = result_reg;

endmodule

FILE: sv/nor_flash_command_sequencer.sv
// NOR flash command sequencer.
// The input channel (in_valid, in_stall) carries one beat per flash clock tick:
// an optional host byte, the RY/BY# level and the sampled flash data word.
// The output channel (out_valid, out_stall) returns one beat for every input
// beat: whether the host byte was consumed, up to two bytes for the host and
// the flash pin levels after that tick.
// A beat passes through an input register, one pass of decode logic and a
// result register. One beat is accepted every cycle while in_stall is low;
// a sector read streams one word per beat.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more beat; only then is in_stall raised.
// Reset returns the sequencer to idle with the address and data latch cleared,
// the bus driven, OE#, WE# and RESET# high and both pipeline stages empty.
module nor_flash_command_sequencer import nfcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 byte_valid,
    input  logic [7:0]           host_byte,
    input  logic                 ready_busy,
    input  logic [15:0]          flash_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 byte_accepted,
    output logic [1:0]           tx_count,
    output logic [15:0]          tx_data,
    output logic [ADDR_BITS-1:0] flash_address,
    output logic [15:0]          write_data,
    output logic                 data_drive,
    output logic                 output_enable_n,
    output logic                 write_enable_n,
    output logic                 reset_n,
    output logic                 tristate
);

    item_t   item_in;
    item_t   item;
    logic    item_valid;
    logic    advance;
    logic    in_load;
    result_t result_next;
    result_t result;

    assign item_in = '{byte_valid: byte_valid, host_byte: host_byte,
                       ready_busy: ready_busy, flash_data: flash_data};

    assign advance  = item_valid && (!out_valid || !out_stall);
    assign in_stall = item_valid && !advance;
    assign in_load  = in_valid && !in_stall;

    nfcs_input_stage u_input
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (in_load),
        .item_in (item_in),
        .advance (advance),
        .valid   (item_valid),
        .item    (item)
    );

    nfcs_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (result_next)
    );

    nfcs_output_stage u_output
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result_in (result_next),
        .stall     (out_stall),
        .valid     (out_valid),
        .result    (result)
    );

    assign byte_accepted   = result.byte_accepted;
    assign tx_count        = result.tx_count;
    assign tx_data         = result.tx_data;
    assign flash_address   = result.flash_address;
    assign write_data      = result.write_data;
    assign data_drive      = result.data_drive;
    assign output_enable_n = result.output_enable_n;
    assign write_enable_n  = result.write_enable_n;
    assign reset_n         = result.reset_n;
    assign tristate        = result.tristate;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the result register could drain");

    a_tx_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tx_count != 2'd3))
        else $error("illegal transmit byte count");

    a_oe_matches_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (output_enable_n == data_drive))
        else $error("OE# low while the data bus is driven");

    a_we_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_enable_n) |-> data_drive)
        else $error("write pulse while the bus is released");

    a_no_byte_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_accepted) |-> (tx_count != TX_TWO))
        else $error("host byte consumed during a sector read beat");
`endif

endmodule
